>>> src/nirdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nirdec_pkg
// shared types, codes and helpers of the nec infrared frame decoder
// ----------------------------------------------------------------------------
package nirdec_pkg;

  // frame length in data bits
  localparam int unsigned FRAME_BITS = 32;

  // item function codes
  localparam logic [1:0] FUNC_EDGE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_WIDTH         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_WIDTH        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TOLERANCE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEATS_PER_EVENT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TIMEOUT      = 3'd6;

  // configuration reset values
  localparam logic [15:0] RST_LEADER_WIDTH      = 16'd13500;
  localparam logic [15:0] RST_REPEAT_WIDTH      = 16'd11250;
  localparam logic [15:0] RST_ONE_WIDTH         = 16'd2250;
  localparam logic [15:0] RST_ZERO_WIDTH        = 16'd1120;
  localparam logic [15:0] RST_WIDTH_TOLERANCE   = 16'd250;
  localparam logic [7:0]  RST_REPEATS_PER_EVENT = 8'd5;
  localparam logic [7:0]  RST_BUSY_TIMEOUT      = 8'd200;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] edge_time;
    logic [7:0]  elapsed_ms;
  } item_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [7:0] command;
    logic       busy_res;
    logic       ready_res;
  } result_t;

  typedef struct packed {
    logic [15:0] leader_width;
    logic [15:0] repeat_width;
    logic [15:0] one_width;
    logic [15:0] zero_width;
    logic [15:0] width_tolerance;
    logic [7:0]  repeats_per_event;
    logic [7:0]  busy_timeout;
  } cfg_t;

  // classified item as it travels through the queue
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] elapsed_ms;
    logic       near_leader;
    logic       near_repeat;
    logic       near_one;
    logic       near_zero;
  } entry_t;

  // strict window test n - tol < w < n + tol, without wrap
  function automatic logic width_near(input logic [15:0] w, input logic [15:0] n,
                                      input logic [15:0] tol);
    logic [16:0] lo_sum;
    logic [16:0] hi_sum;
    lo_sum = {1'b0, w} + {1'b0, tol};
    hi_sum = {1'b0, n} + {1'b0, tol};
    return (lo_sum > {1'b0, n}) && ({1'b0, w} < hi_sum);
  endfunction

endpackage
`default_nettype wire

>>> src/nirdec_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nirdec_front
// accepts items, forms edge widths and classifies them against the windows
// ----------------------------------------------------------------------------
module nirdec_front
  import nirdec_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   item_valid,
  input  wire item_t  item,
  input  wire logic   queue_full,
  output logic        item_stall,
  output logic        push,
  output entry_t      push_entry
);

  logic [15:0] last_edge;
  logic [15:0] width;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;
  assign width      = item.edge_time - last_edge;

  always_comb begin
    push_entry.func        = item.func;
    push_entry.elapsed_ms  = item.elapsed_ms;
    push_entry.near_leader = width_near(width, cfg.leader_width, cfg.width_tolerance);
    push_entry.near_repeat = width_near(width, cfg.repeat_width, cfg.width_tolerance);
    push_entry.near_one    = width_near(width, cfg.one_width, cfg.width_tolerance);
    push_entry.near_zero   = width_near(width, cfg.zero_width, cfg.width_tolerance);
  end

  // edge times are taken in arrival order, so the width is known here
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge <= '0;
    end else if (push && item.func == FUNC_EDGE) begin
      last_edge <= item.edge_time;
    end
  end

endmodule
`default_nettype wire

>>> src/nirdec_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nirdec_queue
// short flop queue between the classifier and the decode engine
// ----------------------------------------------------------------------------
module nirdec_queue
  import nirdec_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        nonempty,
  output entry_t      head
);

  entry_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QPTR_W:0]      count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/nirdec_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nirdec_back
// frame decode state machine, timeout aging, command hand-off, result register
// ----------------------------------------------------------------------------
module nirdec_back
  import nirdec_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   entry_valid,
  input  wire entry_t entry,
  output logic        pop,
  input  wire logic   result_stall,
  output logic        result_valid,
  output result_t     result
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEAD = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] shift_word, shift_word_next;
  logic [7:0]  step_count, step_count_next;
  logic        busy_flag, busy_flag_next;
  logic        ready_flag, ready_flag_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  idle_time, idle_time_next;
  logic        cmd_valid_next;

  logic [7:0]  step_inc;
  logic [8:0]  tick_sum;
  logic [7:0]  tick_sat;
  logic [31:0] shifted;

  assign pop      = entry_valid && (!result_valid || !result_stall);
  assign step_inc = step_count + 8'd1;
  assign tick_sum = {1'b0, idle_time} + {1'b0, entry.elapsed_ms};
  assign tick_sat = tick_sum[8] ? 8'hFF : tick_sum[7:0];
  assign shifted  = {entry.near_zero ? 1'b0 : 1'b1, shift_word[31:1]};

  always_comb begin
    phase_next        = phase;
    shift_word_next   = shift_word;
    step_count_next   = step_count;
    busy_flag_next    = busy_flag;
    ready_flag_next   = ready_flag;
    held_command_next = held_command;
    idle_time_next    = idle_time;
    cmd_valid_next    = 1'b0;

    unique case (entry.func)
      FUNC_EDGE: begin
        busy_flag_next = 1'b1;
        idle_time_next = '0;
        unique case (phase)
          PH_IDLE: begin
            phase_next = PH_LEAD;
          end
          PH_LEAD: begin
            if (entry.near_leader) begin
              step_count_next = '0;
              phase_next      = PH_DATA;
            end else if (entry.near_repeat) begin
              // every repeats_per_event-th repeat code re-raises ready
              if (step_inc >= cfg.repeats_per_event) begin
                step_count_next = '0;
                ready_flag_next = 1'b1;
              end else begin
                step_count_next = step_inc;
              end
              phase_next     = PH_IDLE;
              busy_flag_next = 1'b0;
            end else begin
              step_count_next = '0;
              phase_next      = PH_IDLE;
            end
          end
          PH_DATA: begin
            shift_word_next = {1'b0, shift_word[31:1]};
            if (entry.near_zero || entry.near_one) begin
              shift_word_next = shifted;
              if (step_inc >= 8'(FRAME_BITS)) begin
                step_count_next = '0;
                // address and command bytes against their inverses
                if (shifted[7:0] == ~shifted[15:8] && shifted[23:16] == ~shifted[31:24]) begin
                  ready_flag_next   = 1'b1;
                  held_command_next = shifted[23:16];
                end
                phase_next     = PH_IDLE;
                busy_flag_next = 1'b0;
              end else begin
                step_count_next = step_inc;
              end
            end else begin
              step_count_next = '0;
              phase_next      = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      FUNC_TICK: begin
        if (busy_flag) begin
          idle_time_next = tick_sat;
          if (tick_sat >= cfg.busy_timeout) begin
            phase_next     = PH_IDLE;
            idle_time_next = '0;
            busy_flag_next = 1'b0;
          end
        end
      end
      FUNC_READ: begin
        if (ready_flag) begin
          ready_flag_next = 1'b0;
          cmd_valid_next  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      shift_word   <= '0;
      step_count   <= '0;
      busy_flag    <= 1'b0;
      ready_flag   <= 1'b0;
      held_command <= '0;
      idle_time    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        shift_word   <= shift_word_next;
        step_count   <= step_count_next;
        busy_flag    <= busy_flag_next;
        ready_flag   <= ready_flag_next;
        held_command <= held_command_next;
        idle_time    <= idle_time_next;
        result_valid <= 1'b1;
        result.cmd_valid <= cmd_valid_next;
        result.command   <= held_command_next;
        result.busy_res  <= busy_flag_next;
        result.ready_res <= ready_flag_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_time_only_busy: assert property (@(posedge clk) disable iff (rst)
    !busy_flag |-> idle_time == '0)
    else $error("idle time nonzero while not busy");

  a_data_count_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> step_count < 8'(FRAME_BITS))
    else $error("bit count out of frame while receiving data");

  a_read_hands_out: assert property (@(posedge clk) disable iff (rst)
    pop && entry.func == FUNC_READ && ready_flag |=>
      !ready_flag && result_valid && result.cmd_valid)
    else $error("read of pending command did not hand it out");
`endif

endmodule
`default_nettype wire

>>> src/nec_ir_frame_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// nec infrared frame decoder fed with edge, tick and read items
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | transaction when
//  ---------+-------------------------------------------+--------------------
//  item     | item_valid, item_stall, item (item_t)     | valid && !stall
//  result   | result_valid, result_stall, result        | valid && !stall
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
//  one item per cycle while no result stall holds the back; the front classifies
//  each item into the queue, the back updates state into the result register
//  rst (synchronous) loads the default windows and clears all decode state
//  a stalled result holds the back while the front keeps filling the
//  four-entry queue; item_stall rises only when that queue is full
//  cfg_ready is always high; registers may change only while no item is in flight
//
module nec_ir_frame_decoder_core
  import nirdec_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  cfg_t   cfg;
  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   queue_nonempty;
  entry_t queue_head;
  logic   pop;

  // register file, always able to take a write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_width      <= RST_LEADER_WIDTH;
      cfg.repeat_width      <= RST_REPEAT_WIDTH;
      cfg.one_width         <= RST_ONE_WIDTH;
      cfg.zero_width        <= RST_ZERO_WIDTH;
      cfg.width_tolerance   <= RST_WIDTH_TOLERANCE;
      cfg.repeats_per_event <= RST_REPEATS_PER_EVENT;
      cfg.busy_timeout      <= RST_BUSY_TIMEOUT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEADER_WIDTH:      cfg.leader_width      <= cfg_data;
        CFG_REPEAT_WIDTH:      cfg.repeat_width      <= cfg_data;
        CFG_ONE_WIDTH:         cfg.one_width         <= cfg_data;
        CFG_ZERO_WIDTH:        cfg.zero_width        <= cfg_data;
        CFG_WIDTH_TOLERANCE:   cfg.width_tolerance   <= cfg_data;
        CFG_REPEATS_PER_EVENT: cfg.repeats_per_event <= cfg_data[7:0];
        CFG_BUSY_TIMEOUT:      cfg.busy_timeout      <= cfg_data[7:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // front: width forming and window classification
  nirdec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .queue_full (queue_full),
    .item_stall (item_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples the classifier from result back-pressure
  nirdec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .nonempty   (queue_nonempty),
    .head       (queue_head)
  );

  // back: frame state machine and result register
  nirdec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .entry_valid  (queue_nonempty),
    .entry        (queue_head),
    .pop          (pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire
